>>> hw/rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared constants, register indexes, mode codes and types for the
// stereo to surround gain mixer.
// ----------------------------------------------------------------------------
package sgm_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_W          = 24;
    localparam int FRAC_W          = 23;
    localparam int THR_W           = 23;
    localparam int MODE_W          = 2;
    localparam int INV_W           = COEF_W + 3;
    localparam int GAIN_OP_W       = COEF_W + 1;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = COEF_W;
    localparam int PIPE_DEPTH      = 5;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADROOM_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_DEGREE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_SCALE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SURROUND_SCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE    = 3'd7;

    localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_2_0_0  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_0_2_0  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_3_2_0  = 2'd3;

    localparam logic [COEF_W-1:0] RST_INPUT_GAIN     = 24'd4204234;
    localparam logic [COEF_W-1:0] RST_HEADROOM_GAIN  = 24'd5938679;
    localparam logic [THR_W-1:0]  RST_LIMIT_THRESH   = 23'd8380219;
    localparam logic [COEF_W-1:0] RST_INVERT_GAIN    = 24'd8388608;
    localparam logic [COEF_W-1:0] RST_FRONT_SCALE    = 24'd4204234;
    localparam logic [COEF_W-1:0] RST_SURROUND_SCALE = 24'd6663271;
    localparam logic [MODE_W-1:0] RST_OUTPUT_MODE    = MODE_2_0_0;

    // 1.0 in Q.23, also the inverter coefficient with degree zero
    localparam logic signed [INV_W-1:0] INV_ONE = INV_W'(1) <<< FRAC_W;

    typedef struct packed {
        logic [COEF_W-1:0]       input_gain;
        logic [COEF_W-1:0]       headroom_gain;
        logic [THR_W-1:0]        limit_threshold;
        logic signed [INV_W-1:0] inv_coef;
        logic [COEF_W-1:0]       invert_gain;
        logic [COEF_W-1:0]       front_scale;
        logic [COEF_W-1:0]       surround_scale;
        logic [MODE_W-1:0]       output_mode;
    } t_cfg;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
        logic [PIPE_DEPTH-1:0] valid;
    } t_pipe;

endpackage

>>> hw/rtl/sgm_in_if.sv
// ----------------------------------------------------------------------------
// sgm_in_if
// Stereo input channel: valid/ready with one sample pair per transfer.
// ----------------------------------------------------------------------------
interface sgm_in_if #(
    parameter int SAMPLE_BITS = sgm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

>>> hw/rtl/sgm_out_if.sv
// ----------------------------------------------------------------------------
// sgm_out_if
// Five channel output: valid/ready with one sample set per transfer.
// ----------------------------------------------------------------------------
interface sgm_out_if #(
    parameter int SAMPLE_BITS = sgm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic signed [SAMPLE_BITS-1:0] out_center;
    logic signed [SAMPLE_BITS-1:0] out_left_surround;
    logic signed [SAMPLE_BITS-1:0] out_right_surround;

    modport source (
        output valid, output out_left, output out_right, output out_center,
        output out_left_surround, output out_right_surround, input ready
    );
    modport sink (
        input valid, input out_left, input out_right, input out_center,
        input out_left_surround, input out_right_surround, output ready
    );
endinterface

>>> hw/rtl/sgm_cfg_regs.sv
// ----------------------------------------------------------------------------
// sgm_cfg_regs
// Configuration register file. The inverter coefficient (1 - 2*degree)
// is formed at write time so the datapath sees a ready operand.
// ----------------------------------------------------------------------------
module sgm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sgm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output sgm_pkg::t_cfg                    o_cfg
);

    sgm_pkg::t_cfg r_cfg;
    sgm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sgm_pkg::REG_INPUT_GAIN:     n_cfg.input_gain = i_cfg_data;
                sgm_pkg::REG_HEADROOM_GAIN:  n_cfg.headroom_gain = i_cfg_data;
                sgm_pkg::REG_LIMIT_THRESH:
                    n_cfg.limit_threshold = i_cfg_data[sgm_pkg::THR_W-1:0];
                sgm_pkg::REG_INVERT_DEGREE:
                    n_cfg.inv_coef = sgm_pkg::INV_ONE - $signed({2'b00, i_cfg_data, 1'b0});
                sgm_pkg::REG_INVERT_GAIN:    n_cfg.invert_gain = i_cfg_data;
                sgm_pkg::REG_FRONT_SCALE:    n_cfg.front_scale = i_cfg_data;
                sgm_pkg::REG_SURROUND_SCALE: n_cfg.surround_scale = i_cfg_data;
                sgm_pkg::REG_OUTPUT_MODE:
                    n_cfg.output_mode = i_cfg_data[sgm_pkg::MODE_W-1:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_gain      <= sgm_pkg::RST_INPUT_GAIN;
            r_cfg.headroom_gain   <= sgm_pkg::RST_HEADROOM_GAIN;
            r_cfg.limit_threshold <= sgm_pkg::RST_LIMIT_THRESH;
            r_cfg.inv_coef        <= sgm_pkg::INV_ONE;
            r_cfg.invert_gain     <= sgm_pkg::RST_INVERT_GAIN;
            r_cfg.front_scale     <= sgm_pkg::RST_FRONT_SCALE;
            r_cfg.surround_scale  <= sgm_pkg::RST_SURROUND_SCALE;
            r_cfg.output_mode     <= sgm_pkg::RST_OUTPUT_MODE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/sgm_mul_sat.sv
// ----------------------------------------------------------------------------
// sgm_mul_sat
// Signed sample times coefficient, floored by 2^23, clamped to [lo, hi].
// ----------------------------------------------------------------------------
module sgm_mul_sat #(
    parameter int A_W = 26,
    parameter int C_W = 25,
    parameter int O_W = 24
) (
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [C_W-1:0] i_c,
    input  logic signed [O_W-1:0] i_lo,
    input  logic signed [O_W-1:0] i_hi,
    output logic signed [O_W-1:0] o_y
);

    localparam int P_W = A_W + C_W;
    localparam int Q_W = P_W - sgm_pkg::FRAC_W;

    logic signed [P_W-1:0] prod;
    logic signed [Q_W-1:0] q;
    logic signed [Q_W-1:0] lo_x;
    logic signed [Q_W-1:0] hi_x;
    logic signed [Q_W-1:0] q_sat;

    assign prod = P_W'(i_a) * P_W'(i_c);
    assign q    = prod[P_W-1:sgm_pkg::FRAC_W];
    assign lo_x = Q_W'(i_lo);
    assign hi_x = Q_W'(i_hi);

    always_comb begin
        priority if (q > hi_x) begin
            q_sat = hi_x;
        end else if (q < lo_x) begin
            q_sat = lo_x;
        end else begin
            q_sat = q;
        end
    end

    assign o_y = O_W'(q_sat);

endmodule

>>> hw/rtl/sgm_pipe_ctl.sv
// ----------------------------------------------------------------------------
// sgm_pipe_ctl
// Valid bits and per-stage load enables for the datapath. A stage loads
// when it is empty or the stage after it moves, so bubbles close up.
// ----------------------------------------------------------------------------
module sgm_pipe_ctl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output sgm_pkg::t_pipe o_pipe
);

    localparam int D = sgm_pkg::PIPE_DEPTH;

    logic [D-1:0] r_valid;
    logic [D-1:0] n_valid;
    logic [D:0]   rdy;

    always_comb begin
        rdy[D] = i_out_ready;
        for (int k = D - 1; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
        n_valid = r_valid;
        for (int k = 0; k < D; k++) begin
            if (rdy[k]) begin
                n_valid[k] = (k == 0) ? i_in_valid : r_valid[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready   = rdy[0];
    assign o_pipe.load  = rdy[D-1:0];
    assign o_pipe.valid = r_valid;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_valid) && !i_out_ready)
        else $error("input held off while a stage is empty");
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[D-1] && !i_out_ready |=> r_valid[D-1])
        else $error("stalled result lost");
`endif

endmodule

>>> hw/rtl/stereo_to_surround_gain_mixer.sv
// ----------------------------------------------------------------------------
// stereo_to_surround_gain_mixer
// Stereo pair in, five channels out (L, R, C, Ls, Rs) with gains, limiting
// and output mode selection.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : valid/ready sink, one stereo pair (in_left, in_right) per transfer.
//   o_out : valid/ready source, five samples per transfer.
//   cfg   : i_cfg_we/i_cfg_idx/i_cfg_data write port, write only while idle.
// Stages: one register stage per multiply level (input gain, inverter
//   coefficient, headroom/inverter gain, front/surround scale, final add and
//   limit), five in all.
// Throughput: one pair per cycle unless an o_out stall fills every stage;
//   the stage order of the multipliers sets the latency, nothing is shared.
// Reset: config registers return to their defaults, all valid bits clear.
// Stall: results hold on o_out; the stages behind fill up and i_in.ready
//   drops only once all five stages hold an item.
// ----------------------------------------------------------------------------
module stereo_to_surround_gain_mixer #(
    parameter int SAMPLE_BITS = sgm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sgm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    sgm_in_if.sink                          i_in,
    sgm_out_if.source                       o_out
);

    localparam int S    = SAMPLE_BITS;
    localparam int GW   = S + 2;
    localparam int SW   = S + 3;
    localparam int VW   = S + 4;
    localparam int TW   = S + 2;
    localparam int LW   = S + 3;
    localparam int GC_W = sgm_pkg::GAIN_OP_W;
    localparam int IC_W = sgm_pkg::INV_W;

    localparam logic signed [S-1:0]  SMAX  = {1'b0, {(S-1){1'b1}}};
    localparam logic signed [S-1:0]  SMIN  = {1'b1, {(S-1){1'b0}}};
    localparam logic signed [GW-1:0] GMAX  = {1'b0, {(GW-1){1'b1}}};
    localparam logic signed [GW-1:0] GMIN  = {1'b1, {(GW-1){1'b0}}};
    localparam logic signed [VW-1:0] VMAX  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN  = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [TW-1:0] TMAX  = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] TMIN  = {1'b1, {(TW-1){1'b0}}};

    sgm_pkg::t_cfg  cfg;
    sgm_pkg::t_pipe pipe;

    logic [S-2:0]          thr;
    logic signed [S-1:0]   thr_s;
    logic signed [S-1:0]   thr_n;

    logic signed [GC_W-1:0] ig_op;
    logic signed [GC_W-1:0] hg_op;
    logic signed [GC_W-1:0] vg_op;
    logic signed [GC_W-1:0] fs_op;
    logic signed [GC_W-1:0] ss_op;

    // stage 1
    logic signed [S-1:0]  r1_xl, r1_xr;
    logic signed [GW-1:0] r1_gl, r1_gr;
    logic signed [GW-1:0] n1_gl, n1_gr;
    // stage 2
    logic signed [S-1:0]  r2_xl, r2_xr, r2_c0;
    logic signed [VW-1:0] r2_vl, r2_vr;
    logic signed [S-1:0]  n2_c0;
    logic signed [SW-1:0] sum_c;
    logic signed [VW-1:0] n2_vl, n2_vr;
    // stage 3
    logic signed [S-1:0]  r3_xl, r3_xr, r3_c1, r3_wl, r3_wr;
    logic signed [S-1:0]  n3_c1, n3_wl, n3_wr;
    // stage 4
    logic signed [S-1:0]  r4_xl, r4_xr, r4_c1, r4_f;
    logic signed [TW-1:0] r4_tl, r4_tr;
    logic signed [S-1:0]  n4_f;
    logic signed [TW-1:0] n4_tl, n4_tr;
    // stage 5
    logic signed [LW-1:0] sum_l, sum_r;
    logic signed [S-1:0]  n5_ls, n5_rs;
    logic signed [S-1:0]  n5_left, n5_right, n5_center, n5_lsur, n5_rsur;
    logic signed [S-1:0]  r5_left, r5_right, r5_center, r5_lsur, r5_rsur;

    sgm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sgm_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_pipe      (pipe)
    );

    // limit aligned to the sample's fraction bits
    if (S >= 24) begin : g_thr_up
        assign thr = (S-1)'(cfg.limit_threshold) << (S - 24);
    end else begin : g_thr_dn
        assign thr = (S-1)'(cfg.limit_threshold >> (24 - S));
    end
    assign thr_s = $signed({1'b0, thr});
    assign thr_n = -thr_s;

    assign ig_op = $signed({1'b0, cfg.input_gain});
    assign hg_op = $signed({1'b0, cfg.headroom_gain});
    assign vg_op = $signed({1'b0, cfg.invert_gain});
    assign fs_op = $signed({1'b0, cfg.front_scale});
    assign ss_op = $signed({1'b0, cfg.surround_scale});

    // stage 1: input gain
    sgm_mul_sat #(.A_W(S), .C_W(GC_W), .O_W(GW)) u_gl (
        .i_a(i_in.in_left), .i_c(ig_op), .i_lo(GMIN), .i_hi(GMAX), .o_y(n1_gl));
    sgm_mul_sat #(.A_W(S), .C_W(GC_W), .O_W(GW)) u_gr (
        .i_a(i_in.in_right), .i_c(ig_op), .i_lo(GMIN), .i_hi(GMAX), .o_y(n1_gr));

    always_ff @(posedge i_clk) begin
        if (pipe.load[0]) begin
            r1_xl <= i_in.in_left;
            r1_xr <= i_in.in_right;
            r1_gl <= n1_gl;
            r1_gr <= n1_gr;
        end
    end

    // stage 2: center sum limit, inverter coefficient
    assign sum_c = SW'(r1_gl) + SW'(r1_gr);
    always_comb begin
        priority if (sum_c > SW'(thr_s)) begin
            n2_c0 = thr_s;
        end else if (sum_c < SW'(thr_n)) begin
            n2_c0 = thr_n;
        end else begin
            n2_c0 = S'(sum_c);
        end
    end

    sgm_mul_sat #(.A_W(GW), .C_W(IC_W), .O_W(VW)) u_vl (
        .i_a(r1_gl), .i_c(cfg.inv_coef), .i_lo(VMIN), .i_hi(VMAX), .o_y(n2_vl));
    sgm_mul_sat #(.A_W(GW), .C_W(IC_W), .O_W(VW)) u_vr (
        .i_a(r1_gr), .i_c(cfg.inv_coef), .i_lo(VMIN), .i_hi(VMAX), .o_y(n2_vr));

    always_ff @(posedge i_clk) begin
        if (pipe.load[1]) begin
            r2_xl <= r1_xl;
            r2_xr <= r1_xr;
            r2_c0 <= n2_c0;
            r2_vl <= n2_vl;
            r2_vr <= n2_vr;
        end
    end

    // stage 3: headroom gain, inverter gain
    sgm_mul_sat #(.A_W(S), .C_W(GC_W), .O_W(S)) u_c1 (
        .i_a(r2_c0), .i_c(hg_op), .i_lo(SMIN), .i_hi(SMAX), .o_y(n3_c1));
    sgm_mul_sat #(.A_W(VW), .C_W(GC_W), .O_W(S)) u_wl (
        .i_a(r2_vl), .i_c(vg_op), .i_lo(thr_n), .i_hi(thr_s), .o_y(n3_wl));
    sgm_mul_sat #(.A_W(VW), .C_W(GC_W), .O_W(S)) u_wr (
        .i_a(r2_vr), .i_c(vg_op), .i_lo(thr_n), .i_hi(thr_s), .o_y(n3_wr));

    always_ff @(posedge i_clk) begin
        if (pipe.load[2]) begin
            r3_xl <= r2_xl;
            r3_xr <= r2_xr;
            r3_c1 <= n3_c1;
            r3_wl <= n3_wl;
            r3_wr <= n3_wr;
        end
    end

    // stage 4: front scale, surround scale
    sgm_mul_sat #(.A_W(S), .C_W(GC_W), .O_W(S)) u_f (
        .i_a(r3_c1), .i_c(fs_op), .i_lo(SMIN), .i_hi(SMAX), .o_y(n4_f));
    sgm_mul_sat #(.A_W(S), .C_W(GC_W), .O_W(TW)) u_tl (
        .i_a(r3_wl), .i_c(ss_op), .i_lo(TMIN), .i_hi(TMAX), .o_y(n4_tl));
    sgm_mul_sat #(.A_W(S), .C_W(GC_W), .O_W(TW)) u_tr (
        .i_a(r3_wr), .i_c(ss_op), .i_lo(TMIN), .i_hi(TMAX), .o_y(n4_tr));

    always_ff @(posedge i_clk) begin
        if (pipe.load[3]) begin
            r4_xl <= r3_xl;
            r4_xr <= r3_xr;
            r4_c1 <= r3_c1;
            r4_f  <= n4_f;
            r4_tl <= n4_tl;
            r4_tr <= n4_tr;
        end
    end

    // stage 5: surround mix, limit, mode select
    assign sum_l = LW'(r4_tl) + LW'(r4_f);
    assign sum_r = LW'(r4_tr) + LW'(r4_f);

    always_comb begin
        priority if (sum_l > LW'(thr_s)) begin
            n5_ls = thr_s;
        end else if (sum_l < LW'(thr_n)) begin
            n5_ls = thr_n;
        end else begin
            n5_ls = S'(sum_l);
        end
        priority if (sum_r > LW'(thr_s)) begin
            n5_rs = thr_s;
        end else if (sum_r < LW'(thr_n)) begin
            n5_rs = thr_n;
        end else begin
            n5_rs = S'(sum_r);
        end
    end

    always_comb begin
        n5_center = r4_c1;
        n5_lsur   = n5_ls;
        n5_rsur   = n5_rs;
        unique case (cfg.output_mode)
            sgm_pkg::MODE_BYPASS: begin
                n5_left   = r4_xl;
                n5_right  = r4_xr;
                n5_center = '0;
                n5_lsur   = '0;
                n5_rsur   = '0;
            end
            sgm_pkg::MODE_0_2_0: begin
                n5_left  = n5_ls;
                n5_right = n5_rs;
            end
            sgm_pkg::MODE_2_0_0, sgm_pkg::MODE_3_2_0: begin
                n5_left  = r4_f;
                n5_right = r4_f;
            end
            default: begin
                n5_left  = r4_f;
                n5_right = r4_f;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pipe.load[4]) begin
            r5_left   <= n5_left;
            r5_right  <= n5_right;
            r5_center <= n5_center;
            r5_lsur   <= n5_lsur;
            r5_rsur   <= n5_rsur;
        end
    end

    assign o_out.valid              = pipe.valid[4];
    assign o_out.out_left           = r5_left;
    assign o_out.out_right          = r5_right;
    assign o_out.out_center         = r5_center;
    assign o_out.out_left_surround  = r5_lsur;
    assign o_out.out_right_surround = r5_rsur;

`ifndef SYNTHESIS
    a_ls_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && cfg.output_mode != sgm_pkg::MODE_BYPASS
        |-> r5_lsur <= thr_s && r5_lsur >= thr_n)
        else $error("left surround beyond limit");
    a_rs_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && cfg.output_mode != sgm_pkg::MODE_BYPASS
        |-> r5_rsur <= thr_s && r5_rsur >= thr_n)
        else $error("right surround beyond limit");
`endif

endmodule
